FILE: design/qpd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qpd_pkg: shared types, constants and microcode for the quadrotor PD core
// Payload structs, loop gains and limits, mixing coefficients, control ROM.
// ----------------------------------------------------------------------------
package qpd_pkg;

  localparam int ACCW = 56;   // PD accumulator
  localparam int DIVW = 53;   // derivative dividend magnitude
  localparam int SQW  = 48;   // radicand width
  localparam int PCW  = 6;
  localparam int CNTW = 6;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [31:0] orient_x;
    logic signed [31:0] orient_y;
    logic signed [31:0] orient_z;
    logic        [30:0] elapsed_time;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] motor_one;
    logic        [30:0] motor_two;
    logic        [30:0] motor_three;
    logic signed [31:0] motor_four;
  } out_item_t;

  typedef enum logic [2:0] {
    REG_X_TARGET   = 3'd0,
    REG_Y_TARGET   = 3'd1,
    REG_Z_TARGET   = 3'd2,
    REG_YAW_TARGET = 3'd3,
    REG_HOVER      = 3'd4
  } cfg_reg_t;

  // loop indexes
  localparam logic [2:0] L_ALT   = 3'd0;
  localparam logic [2:0] L_YAW   = 3'd1;
  localparam logic [2:0] L_X     = 3'd2;
  localparam logic [2:0] L_Y     = 3'd3;
  localparam logic [2:0] L_ROLL  = 3'd4;
  localparam logic [2:0] L_PITCH = 3'd5;

  localparam logic signed [31:0] ALT_KP = 32'sd524288;
  localparam logic signed [31:0] ALT_KD = 32'sd376832;
  localparam logic signed [31:0] YAW_KP = 32'sd3277;
  localparam logic signed [31:0] YAW_KD = 32'sd2621;
  localparam logic signed [31:0] ATT_KP = 32'sd5243;
  localparam logic signed [31:0] ATT_KD = 32'sd3277;
  localparam logic signed [31:0] POS_KP = 32'sd6554;
  localparam logic signed [31:0] POS_KD = 32'sd9830;
  localparam logic signed [31:0] ALT_MIN = 32'sd1310720;
  localparam logic signed [31:0] ALT_MAX = 32'sd2129920;
  localparam logic signed [31:0] TILT_LIM = 32'sd6554;
  localparam logic signed [31:0] TORQUE_LIM = 32'sd655;
  localparam logic signed [31:0] MIX_C1 = 32'sd32768000;
  localparam logic signed [31:0] MIX_C2 = 32'sd1776043360;
  localparam logic signed [31:0] MIX_C3 = 32'sd1496255708;
  localparam logic signed [31:0] MIX_C4 = 32'sd109226667;

  typedef enum logic [3:0] {
    OP_ERR, OP_MULP, OP_MULD, OP_DIV, OP_FIN,
    OP_MIX, OP_SUM, OP_SQRT, OP_DONE
  } uop_t;

  typedef struct packed {
    uop_t       op;
    logic [2:0] idx;
  } uword_t;

  function automatic logic signed [31:0] loop_kp(input logic [2:0] idx);
    case (idx)
      L_ALT:            return ALT_KP;
      L_YAW:            return YAW_KP;
      L_X, L_Y:         return POS_KP;
      default:          return ATT_KP;
    endcase
  endfunction

  function automatic logic signed [31:0] loop_kd(input logic [2:0] idx);
    case (idx)
      L_ALT:            return ALT_KD;
      L_YAW:            return YAW_KD;
      L_X, L_Y:         return POS_KD;
      default:          return ATT_KD;
    endcase
  endfunction

  function automatic logic signed [31:0] loop_lo(input logic [2:0] idx);
    case (idx)
      L_ALT:            return ALT_MIN;
      L_X, L_Y:         return -TILT_LIM;
      default:          return -TORQUE_LIM;
    endcase
  endfunction

  function automatic logic signed [31:0] loop_hi(input logic [2:0] idx);
    case (idx)
      L_ALT:            return ALT_MAX;
      L_X, L_Y:         return TILT_LIM;
      default:          return TORQUE_LIM;
    endcase
  endfunction

  // control ROM: five steps per PD loop, then mixing and square roots
  function automatic uword_t ucode(input logic [PCW-1:0] pc);
    case (pc)
      6'd0:  return '{OP_ERR,  L_ALT};
      6'd1:  return '{OP_MULP, L_ALT};
      6'd2:  return '{OP_MULD, L_ALT};
      6'd3:  return '{OP_DIV,  L_ALT};
      6'd4:  return '{OP_FIN,  L_ALT};
      6'd5:  return '{OP_ERR,  L_YAW};
      6'd6:  return '{OP_MULP, L_YAW};
      6'd7:  return '{OP_MULD, L_YAW};
      6'd8:  return '{OP_DIV,  L_YAW};
      6'd9:  return '{OP_FIN,  L_YAW};
      6'd10: return '{OP_ERR,  L_X};
      6'd11: return '{OP_MULP, L_X};
      6'd12: return '{OP_MULD, L_X};
      6'd13: return '{OP_DIV,  L_X};
      6'd14: return '{OP_FIN,  L_X};
      6'd15: return '{OP_ERR,  L_Y};
      6'd16: return '{OP_MULP, L_Y};
      6'd17: return '{OP_MULD, L_Y};
      6'd18: return '{OP_DIV,  L_Y};
      6'd19: return '{OP_FIN,  L_Y};
      6'd20: return '{OP_ERR,  L_ROLL};
      6'd21: return '{OP_MULP, L_ROLL};
      6'd22: return '{OP_MULD, L_ROLL};
      6'd23: return '{OP_DIV,  L_ROLL};
      6'd24: return '{OP_FIN,  L_ROLL};
      6'd25: return '{OP_ERR,  L_PITCH};
      6'd26: return '{OP_MULP, L_PITCH};
      6'd27: return '{OP_MULD, L_PITCH};
      6'd28: return '{OP_DIV,  L_PITCH};
      6'd29: return '{OP_FIN,  L_PITCH};
      6'd30: return '{OP_MIX,  3'd0};
      6'd31: return '{OP_MIX,  3'd1};
      6'd32: return '{OP_MIX,  3'd2};
      6'd33: return '{OP_MIX,  3'd3};
      6'd34: return '{OP_SUM,  3'd0};
      6'd35: return '{OP_SQRT, 3'd0};
      6'd36: return '{OP_SUM,  3'd1};
      6'd37: return '{OP_SQRT, 3'd1};
      6'd38: return '{OP_SUM,  3'd2};
      6'd39: return '{OP_SQRT, 3'd2};
      6'd40: return '{OP_SUM,  3'd3};
      6'd41: return '{OP_SQRT, 3'd3};
      default: return '{OP_DONE, 3'd0};
    endcase
  endfunction

endpackage

FILE: design/quadrotor_cascaded_pd_control_step_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quadrotor_cascaded_pd_control_step_core
// Cascaded PD altitude/yaw/position/attitude loops with four-rotor mixing.
// ----------------------------------------------------------------------------
// Sequence: six PD loops (error, proportional and derivative products, a
//   53-step radix-2 derivative divider that is skipped at dt=0, clamp),
//   4 mixing products, then 4 sums each followed by a 24-step square
//   root, then the output load.
// The next sample is taken once the sequencer is back at idle, while the
//   last result may still be waiting.
// Reset (rst, synchronous): targets and hover thrust to defaults, stored
//   errors to zero, sequencer idle, output empty.
module quadrotor_cascaded_pd_control_step_core
  import qpd_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  in_item_t    in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output out_item_t   out_data,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_idx,
  input  logic [31:0] cfg_data
);

  // configuration
  logic signed [31:0] x_target, y_target, z_target, yaw_target, hover_thrust;

  // sequencer
  logic            busy;
  logic [PCW-1:0]  pc;
  logic [CNTW-1:0] cnt;
  uword_t          uw;

  // datapath state
  in_item_t           smp;
  logic signed [31:0] last_err [6];
  logic signed [31:0] res [6];        // loop outputs: u1, u4, pitch_ref, roll_ref, u2, u3
  logic signed [31:0] e_reg;
  logic signed [32:0] diff_reg;
  logic signed [ACCW-1:0] acc;
  logic [DIVW-1:0]    dvd;            // dividend, shifted into quotient
  logic [31:0]        rem;
  logic               dvd_neg;
  logic signed [63:0] mix [4];        // a, b, c, d products
  logic [SQW-1:0]     sq_v, sq_r, sq_b;
  logic [23:0]        w [4];

  assign uw       = ucode(pc);
  assign in_ready = !busy;

  // ---------------- operand selection ----------------
  logic signed [31:0] tgt, meas;
  always_comb begin
    case (uw.idx)
      L_ALT:   begin tgt = z_target;   meas = smp.pos_z;    end
      L_YAW:   begin tgt = yaw_target; meas = smp.orient_z; end
      L_X:     begin tgt = x_target;   meas = smp.pos_x;    end
      L_Y:     begin tgt = y_target;   meas = smp.pos_y;    end
      L_ROLL:  begin tgt = res[3];     meas = smp.orient_x; end
      default: begin tgt = res[2];     meas = smp.orient_y; end
    endcase
  end

  // error, saturated to 32 bits
  logic signed [32:0] e_wide;
  logic signed [31:0] e_sat;
  assign e_wide = {tgt[31], tgt} - {meas[31], meas};
  always_comb begin
    if (e_wide[32] != e_wide[31]) e_sat = e_wide[32] ? 32'sh8000_0000 : 32'sh7fff_ffff;
    else e_sat = e_wide[31:0];
  end

  // shared multiplier
  logic signed [33:0] mul_a;
  logic signed [31:0] mul_b;
  logic signed [65:0] mul_p;
  always_comb begin
    case (uw.op)
      OP_MULP: begin mul_a = 34'(e_reg);    mul_b = loop_kp(uw.idx); end
      OP_MULD: begin mul_a = 34'(diff_reg); mul_b = loop_kd(uw.idx); end
      default: begin
        case (uw.idx[1:0])
          2'd0:    begin mul_a = 34'(res[4]); mul_b = MIX_C2; end
          2'd1:    begin mul_a = 34'(res[5]); mul_b = MIX_C3; end
          2'd2:    begin mul_a = 34'(res[0]); mul_b = MIX_C1; end
          default: begin mul_a = 34'(res[1]); mul_b = MIX_C4; end
        endcase
      end
    endcase
  end
  assign mul_p = mul_a * mul_b;

  // proportional term: divide by 65536, truncating toward zero
  logic signed [65:0] p_biased;
  logic signed [65:0] p_shift;
  assign p_biased = mul_p + (mul_p[65] ? 66'sd65535 : 66'sd0);
  assign p_shift  = p_biased >>> 16;

  logic [65:0] mul_mag;
  assign mul_mag = mul_p[65] ? 66'(-mul_p) : 66'(mul_p);

  // divider step
  logic [31:0] rem_sh;
  logic        q_bit;
  assign rem_sh = {rem[30:0], dvd[DIVW-1]};
  assign q_bit  = rem_sh >= {1'b0, smp.elapsed_time};

  logic signed [ACCW-1:0] quo_s;
  assign quo_s = dvd_neg ? -ACCW'(dvd) : ACCW'(dvd);

  // loop finish: optional negation (roll target), hover offset, clamp
  logic signed [ACCW-1:0] fin_v, lo_w, hi_w, fin_c;
  always_comb begin
    fin_v = (uw.idx == L_Y) ? -acc : acc;
    if (uw.idx == L_ALT) fin_v = fin_v + ACCW'(hover_thrust);
    lo_w = ACCW'(loop_lo(uw.idx));
    hi_w = ACCW'(loop_hi(uw.idx));
    if (fin_v < lo_w) fin_c = lo_w;
    else if (fin_v > hi_w) fin_c = hi_w;
    else fin_c = fin_v;
  end

  // mixing sum; sign pattern per rotor on a, b, d (c always added)
  logic signed [63:0] s_sum;
  always_comb begin
    case (uw.idx[1:0])
      2'd0:    s_sum =  mix[0] + mix[1] + mix[2] + mix[3];
      2'd1:    s_sum = -mix[0] + mix[1] + mix[2] - mix[3];
      2'd2:    s_sum =  mix[0] - mix[1] + mix[2] - mix[3];
      default: s_sum = -mix[0] - mix[1] + mix[2] + mix[3];
    endcase
  end

  // square root step
  logic [SQW-1:0] sq_t;
  assign sq_t = sq_r + sq_b;

  // ---------------- configuration port ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      x_target     <= 32'sd327680;
      y_target     <= 32'sd327680;
      z_target     <= 32'sd327680;
      yaw_target   <= 32'sd0;
      hover_thrust <= 32'sd1802240;
    end else if (cfg_we) begin
      case (cfg_idx)
        REG_X_TARGET:   x_target     <= cfg_data;
        REG_Y_TARGET:   y_target     <= cfg_data;
        REG_Z_TARGET:   z_target     <= cfg_data;
        REG_YAW_TARGET: yaw_target   <= cfg_data;
        REG_HOVER:      hover_thrust <= cfg_data;
        default: ;
      endcase
    end
  end

  // ---------------- sequencer and control state ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      pc        <= '0;
      cnt       <= '0;
      out_valid <= 1'b0;
      for (int i = 0; i < 6; i++) last_err[i] <= '0;
    end else begin
      // a result transfer empties the output unless a new one loads it
      if (out_valid && out_ready && !(busy && uw.op == OP_DONE)) out_valid <= 1'b0;
      if (!busy) begin
        if (in_valid) begin
          busy <= 1'b1;
          pc   <= '0;
        end
      end else begin
        case (uw.op)
          OP_ERR: begin
            last_err[uw.idx] <= e_sat;
            pc <= pc + 1'b1;
          end
          OP_MULD: begin
            // zero elapsed time: no divide, quotient stays zero
            cnt <= (smp.elapsed_time == '0) ? '0 : CNTW'(DIVW);
            pc  <= pc + 1'b1;
          end
          OP_DIV: begin
            if (cnt != '0) cnt <= cnt - 1'b1;
            else pc <= pc + 1'b1;
          end
          OP_SUM: begin
            cnt <= CNTW'(SQW / 2);
            pc  <= pc + 1'b1;
          end
          OP_SQRT: begin
            if (cnt != '0) cnt <= cnt - 1'b1;
            else pc <= pc + 1'b1;
          end
          OP_DONE: begin
            // hold until the output register is free
            if (!out_valid || out_ready) begin
              out_valid <= 1'b1;
              busy      <= 1'b0;
              pc        <= '0;
            end
          end
          default: pc <= pc + 1'b1;
        endcase
      end
    end
  end

  // ---------------- datapath registers ----------------
  always_ff @(posedge clk) begin
    if (!busy && in_valid) smp <= in_data;
    if (busy) begin
      case (uw.op)
        OP_ERR: begin
          e_reg    <= e_sat;
          diff_reg <= {e_sat[31], e_sat} - {last_err[uw.idx][31], last_err[uw.idx]};
        end
        OP_MULP: acc <= p_shift[ACCW-1:0];
        OP_MULD: begin
          dvd     <= (smp.elapsed_time == '0) ? '0 : mul_mag[DIVW-1:0];
          dvd_neg <= mul_p[65];
          rem     <= '0;
        end
        OP_DIV: begin
          if (cnt != '0) begin
            rem <= q_bit ? rem_sh - {1'b0, smp.elapsed_time} : rem_sh;
            dvd <= {dvd[DIVW-2:0], q_bit};
          end else begin
            acc <= acc + quo_s;
          end
        end
        OP_FIN: res[uw.idx] <= fin_c[31:0];
        OP_MIX: mix[uw.idx[1:0]] <= mul_p[63:0];
        OP_SUM: begin
          sq_v <= (s_sum > 64'sd0) ? s_sum[SQW-1:0] : '0;
          sq_r <= '0;
          sq_b <= SQW'(1) << (SQW - 2);
        end
        OP_SQRT: begin
          if (cnt != '0) begin
            if (sq_v >= sq_t) begin
              sq_v <= sq_v - sq_t;
              sq_r <= (sq_r >> 1) + sq_b;
            end else begin
              sq_r <= sq_r >> 1;
            end
            sq_b <= sq_b >> 2;
          end else begin
            w[uw.idx[1:0]] <= sq_r[23:0];
          end
        end
        OP_DONE: begin
          if (!out_valid || out_ready) begin
            out_data.motor_one   <= -32'(w[0]);
            out_data.motor_two   <= 31'(w[1]);
            out_data.motor_three <= 31'(w[2]);
            out_data.motor_four  <= -32'(w[3]);
          end
        end
        default: ;
      endcase
    end
  end

endmodule

FILE: sim/quadrotor_cascaded_pd_control_step_core_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quadrotor_cascaded_pd_control_step_core_test
// Drives pose samples through the cascaded PD core and checks every rotor
// speed against a bit-exact predictor held in a small scoreboard class.
// ----------------------------------------------------------------------------
module quadrotor_cascaded_pd_control_step_core_test;
  import qpd_pkg::*;

  // --------------------------------------------------------------------------
  // Scoreboard: its own copy of targets and stored errors, predicts the four
  // rotor speeds for each accepted sample and checks them in order.
  // --------------------------------------------------------------------------
  class rotor_scoreboard;
    longint tgt_x, tgt_y, tgt_z, tgt_yaw, hover;
    longint prev_alt, prev_yaw, prev_x, prev_y, prev_roll, prev_pitch;
    out_item_t pending[$];
    int mismatches;

    function void reset_state();
      tgt_x = 327680; tgt_y = 327680; tgt_z = 327680;
      tgt_yaw = 0; hover = 1802240;
      prev_alt = 0; prev_yaw = 0; prev_x = 0;
      prev_y = 0; prev_roll = 0; prev_pitch = 0;
    endfunction

    function void write_reg(logic [2:0] idx, logic [31:0] val);
      longint v;
      v = longint'($signed(val));
      case (idx)
        REG_X_TARGET:   tgt_x = v;
        REG_Y_TARGET:   tgt_y = v;
        REG_Z_TARGET:   tgt_z = v;
        REG_YAW_TARGET: tgt_yaw = v;
        REG_HOVER:      hover = v;
        default: ;
      endcase
    endfunction

    function longint clip(longint v, longint lo, longint hi);
      return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    // division truncates toward zero, as does SV signed '/'
    function longint pd(longint err, longint prev, longint kp, longint kd,
                        longint dt);
      longint p, d;
      p = (kp * err) / 65536;
      d = (dt != 0) ? (kd * (err - prev)) / dt : 0;
      return p + d;
    endfunction

    function longint speed(longint half_sq);
      longint unsigned v, r, b;
      if (half_sq <= 0) return 0;
      v = half_sq; r = 0; b = 64'd1 << 62;
      while (b > v) b >>= 2;
      while (b != 0) begin
        if (v >= r + b) begin
          v -= r + b;
          r = (r >> 1) + b;
        end else begin
          r >>= 1;
        end
        b >>= 2;
      end
      return longint'(r);
    endfunction

    function void note_sample(in_item_t s);
      longint lo_e, hi_e, dt, e, u1, u2, u3, u4, pitch_ref, roll_ref;
      longint a, b, c, d;
      out_item_t r;
      lo_e = -64'sd2147483648; hi_e = 64'sd2147483647;
      dt = longint'(s.elapsed_time);
      e = clip(tgt_z - longint'(s.pos_z), lo_e, hi_e);
      u1 = clip(pd(e, prev_alt, ALT_KP, ALT_KD, dt) + hover, ALT_MIN, ALT_MAX);
      prev_alt = e;
      e = clip(tgt_yaw - longint'(s.orient_z), lo_e, hi_e);
      u4 = clip(pd(e, prev_yaw, YAW_KP, YAW_KD, dt), -TORQUE_LIM, TORQUE_LIM);
      prev_yaw = e;
      e = clip(tgt_x - longint'(s.pos_x), lo_e, hi_e);
      pitch_ref = clip(pd(e, prev_x, POS_KP, POS_KD, dt), -TILT_LIM, TILT_LIM);
      prev_x = e;
      e = clip(tgt_y - longint'(s.pos_y), lo_e, hi_e);
      roll_ref = clip(-pd(e, prev_y, POS_KP, POS_KD, dt), -TILT_LIM, TILT_LIM);
      prev_y = e;
      e = clip(roll_ref - longint'(s.orient_x), lo_e, hi_e);
      u2 = clip(pd(e, prev_roll, ATT_KP, ATT_KD, dt), -TORQUE_LIM, TORQUE_LIM);
      prev_roll = e;
      e = clip(pitch_ref - longint'(s.orient_y), lo_e, hi_e);
      u3 = clip(pd(e, prev_pitch, ATT_KP, ATT_KD, dt), -TORQUE_LIM, TORQUE_LIM);
      prev_pitch = e;
      a = u2 * MIX_C2; b = u3 * MIX_C3; c = u1 * MIX_C1; d = u4 * MIX_C4;
      r.motor_one   = 32'(-speed(a + b + c + d));
      r.motor_two   = 31'(speed(-a + b + c - d));
      r.motor_three = 31'(speed(a - b + c - d));
      r.motor_four  = 32'(-speed(-a - b + c + d));
      pending.push_back(r);
    endfunction

    function void check_result(out_item_t got);
      out_item_t exp_r;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h", got);
        return;
      end
      exp_r = pending.pop_front();
      if (got !== exp_r) begin
        mismatches++;
        if (mismatches <= 10)
          $display("rotor mismatch: exp %h %h %h %h got %h %h %h %h",
                   exp_r.motor_one, exp_r.motor_two, exp_r.motor_three,
                   exp_r.motor_four, got.motor_one, got.motor_two,
                   got.motor_three, got.motor_four);
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  in_item_t    in_data = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  out_item_t   out_data;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_idx = '0;
  logic [31:0] cfg_data = '0;

  rotor_scoreboard sb = new();
  bit quiet_tail = 0;   // no idling in the last part of the run
  int stall_cycles = 0;

  always #10 clk = ~clk;

  quadrotor_cascaded_pd_control_step_core DUT (.*);

  // sink side: random bursts of stall, checks each result transfer
  initial begin : sink
    int burst;
    forever begin
      @(posedge clk);
      if (!rst && out_valid && out_ready) sb.check_result(out_data);
      if (burst > 0) begin
        burst--;
        out_ready <= 1'b0;
      end else if (!quiet_tail && $urandom_range(0, 9) == 0) begin
        burst = $urandom_range(1, 16) - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // watchdog: cycles with no transfer on either channel
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
    if (stall_cycles > 20000) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // valid stays high into the next sample unless an idle burst drops it
  task automatic send_sample(in_item_t s);
    if (!quiet_tail && $urandom_range(0, 7) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= s;
    do @(posedge clk); while (!in_ready);
    sb.note_sample(s);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (600) @(posedge clk);  // core may still be busy on nothing
  endtask

  task automatic write_cfg(logic [2:0] idx, logic [31:0] val);
    cfg_we <= 1'b1; cfg_idx <= idx; cfg_data <= val;
    @(posedge clk);
    sb.write_reg(idx, val);
  endtask

  function automatic logic [31:0] rand_word(int mode);
    case (mode)
      0: return $urandom();
      1: return 32'($signed($urandom_range(0, 1310720)) - 655360);
      2: return $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000;
      default: return 32'($signed($urandom_range(0, 20000)) - 10000);
    endcase
  endfunction

  function automatic in_item_t rand_sample();
    in_item_t s;
    int m;
    m = $urandom_range(0, 9) < 7 ? 1 : $urandom_range(0, 3);
    s.pos_x = rand_word(m); s.pos_y = rand_word(m); s.pos_z = rand_word(m);
    s.orient_x = rand_word(m == 1 ? 3 : m); s.orient_y = rand_word(m == 1 ? 3 : m);
    s.orient_z = rand_word(m == 1 ? 3 : m);
    case ($urandom_range(0, 5))
      0: s.elapsed_time = 31'd0;
      1: s.elapsed_time = 31'($urandom());
      2: s.elapsed_time = 31'h7fffffff;
      default: s.elapsed_time = 31'($urandom_range(1, 3000));
    endcase
    return s;
  endfunction

  initial begin : stimulus
    in_item_t s;
    logic [31:0] ext [4];
    sb.reset_state();
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: field extremes, zero and maximum elapsed time, saturating
    // errors, negative squared speeds
    ext = '{32'h0, 32'h7fffffff, 32'h80000000, 32'hffffffff};
    for (int i = 0; i < 16; i++) begin
      s.pos_x = ext[i % 4]; s.pos_y = ext[(i + 1) % 4];
      s.pos_z = ext[(i / 4) % 4]; s.orient_x = ext[(i + 2) % 4];
      s.orient_y = ext[(i + 3) % 4]; s.orient_z = ext[(i / 2) % 4];
      s.elapsed_time = (i % 3 == 0) ? 31'd0 : (i % 3 == 1 ? 31'h7fffffff : 31'd1);
      send_sample(s);
    end
    drain();  // sender holds off until every result is back

    // several register settings, extremes included, with random samples
    for (int ph = 0; ph < 9; ph++) begin
      if (ph == 8) quiet_tail = 1;
      for (int r = REG_X_TARGET; r <= REG_HOVER; r++)
        write_cfg(3'(r), ph == 1 ? 32'h7fffffff : ph == 2 ? 32'h80000000 :
                  ph == 0 ? 32'd327680 : rand_word(ph % 4));
      if (ph == 3) write_cfg(3'd7, $urandom());  // out-of-range index
      cfg_we <= 1'b0;
      for (int k = 0; k < 105; k++) send_sample(rand_sample());
      drain();
    end

    if (sb.mismatches == 0 && sb.pending.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end
endmodule
